/* src/sorted_wakeup_queue_unit_macros.svh */
// Assertion macros for the sorted wake-up queue.
// Used by the top level only; needs nothing else.
`ifndef SORTED_WAKEUP_QUEUE_UNIT_MACROS_SVH
`define SORTED_WAKEUP_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define SWQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/swq_pkg.sv */
// Shared types and constants of the sorted wake-up queue.
// No dependencies.
package swq_pkg;

    localparam int ID_W      = 8;
    localparam int KEY_W     = 32;
    localparam int CNT_OUT_W = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } t_op;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } t_entry;

    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry fresh;
    } t_cell_cmd;

endpackage

/* src/sorted_wakeup_queue_unit.sv */
// Top level of the sorted wake-up queue: a row of swq_cell slots plus count
// and result register. Uses swq_pkg, swq_cell and the assertion macros.
//
// Usage:
//   Input channel (i_valid / o_ready) carries i_op, i_proc_id, i_wake_time.
//   i_op = insert places the entry ahead of the first stored entry with an
//   equal or later wake time; i_op = pop removes the head entry.
//   Output channel (o_valid / i_ready) returns one result item per input item:
//   pop fields, head wake time, empty flag, count and the dropped-insert flag.
//   The result is registered and presented in the cycle after acceptance.
//   Throughput: one item per cycle; every slot compares its key against the
//   new key in parallel and shifts to its neighbor in the same cycle.
//   The result register is the only buffer: while the receiver stalls with a
//   result pending, o_ready stays low and the store holds.
//   Reset clears the entry count and the result valid; slot contents are not
//   cleared, since only slots below the count are ever read.
//   An insert into a full store leaves it unchanged and flags insert_dropped.
`include "sorted_wakeup_queue_unit_macros.svh"
module sorted_wakeup_queue_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [swq_pkg::ID_W-1:0]      i_proc_id,
    input  logic [swq_pkg::KEY_W-1:0]     i_wake_time,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_pop_valid,
    output logic [swq_pkg::ID_W-1:0]      o_popped_id,
    output logic [swq_pkg::KEY_W-1:0]     o_popped_wake,
    output logic [swq_pkg::KEY_W-1:0]     o_head_wake,
    output logic                          o_queue_empty,
    output logic [swq_pkg::CNT_OUT_W-1:0] o_entry_count,
    output logic                          o_insert_dropped
);
    import swq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_valid;
    logic          n_valid;

    logic                 r_pop_valid, n_pop_valid;
    logic [ID_W-1:0]      r_popped_id, n_popped_id;
    logic [KEY_W-1:0]     r_popped_wake, n_popped_wake;
    logic [KEY_W-1:0]     r_head_wake, n_head_wake;
    logic                 r_queue_empty, n_queue_empty;
    logic [CNT_OUT_W-1:0] r_entry_count, n_entry_count;
    logic                 r_insert_dropped, n_insert_dropped;

    logic      w_accept;
    logic      w_is_pop;
    logic      w_full;
    t_cell_cmd w_cmd;
    t_entry    w_cell [CAPACITY];
    logic      w_ge   [CAPACITY];

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_is_pop = (i_op == OP_POP);
    assign w_full   = (r_count == CAP_CNT);

    assign w_cmd.push      = w_accept && !w_is_pop && !w_full;
    assign w_cmd.pop       = w_accept && w_is_pop && (r_count != '0);
    assign w_cmd.fresh.key = i_wake_time;
    assign w_cmd.fresh.id  = i_proc_id;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;
        logic   w_prev_ge;
        logic   w_slot_valid;

        assign w_slot_valid = (CW'(g) < r_count);

        if (g == 0) begin : g_head
            assign w_prev    = w_cmd.fresh;
            assign w_prev_ge = 1'b0;
        end else begin : g_body
            assign w_prev    = w_cell[g-1];
            assign w_prev_ge = w_ge[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next = w_cell[g];
        end else begin : g_mid
            assign w_next = w_cell[g+1];
        end

        swq_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (w_cmd),
            .i_valid      (w_slot_valid),
            .i_prev_entry (w_prev),
            .i_prev_ge    (w_prev_ge),
            .i_next_entry (w_next),
            .o_entry      (w_cell[g]),
            .o_ge         (w_ge[g])
        );
    end

    always_comb begin
        n_count          = r_count;
        n_valid          = r_valid && !i_ready;
        n_pop_valid      = r_pop_valid;
        n_popped_id      = r_popped_id;
        n_popped_wake    = r_popped_wake;
        n_head_wake      = r_head_wake;
        n_queue_empty    = r_queue_empty;
        n_entry_count    = r_entry_count;
        n_insert_dropped = r_insert_dropped;
        if (w_accept) begin
            n_valid          = 1'b1;
            n_pop_valid      = 1'b0;
            n_popped_id      = '0;
            n_popped_wake    = '0;
            n_insert_dropped = 1'b0;
            n_head_wake      = '0;
            if (w_is_pop) begin
                if (w_cmd.pop) begin
                    n_count       = r_count - CW'(1);
                    n_pop_valid   = 1'b1;
                    n_popped_id   = w_cell[0].id;
                    n_popped_wake = w_cell[0].key;
                    if (r_count > CW'(1)) begin
                        n_head_wake = w_cell[1].key;
                    end
                end
            end else if (w_full) begin
                n_insert_dropped = 1'b1;
                n_head_wake      = w_cell[0].key;
            end else begin
                n_count     = r_count + CW'(1);
                n_head_wake = w_ge[0] ? i_wake_time : w_cell[0].key;
            end
            n_queue_empty = (n_count == '0);
            n_entry_count = CNT_OUT_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop_valid      <= n_pop_valid;
        r_popped_id      <= n_popped_id;
        r_popped_wake    <= n_popped_wake;
        r_head_wake      <= n_head_wake;
        r_queue_empty    <= n_queue_empty;
        r_entry_count    <= n_entry_count;
        r_insert_dropped <= n_insert_dropped;
    end

    assign o_valid          = r_valid;
    assign o_pop_valid      = r_pop_valid;
    assign o_popped_id      = r_popped_id;
    assign o_popped_wake    = r_popped_wake;
    assign o_head_wake      = r_head_wake;
    assign o_queue_empty    = r_queue_empty;
    assign o_entry_count    = r_entry_count;
    assign o_insert_dropped = r_insert_dropped;

    `SWQ_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CAP_CNT, "count overflow")
    `SWQ_ASSERT_IMP(a_head_order, i_clk, i_rst_n, r_count > CW'(1), w_cell[0].key <= w_cell[1].key, "head out of order")
    `SWQ_ASSERT_NEXT(a_pop_empty, i_clk, i_rst_n, w_accept && w_is_pop && (r_count == '0), (r_count == '0) && !o_pop_valid, "pop from empty changed state")
    `SWQ_ASSERT_NEXT(a_full_drop, i_clk, i_rst_n, w_accept && !w_is_pop && w_full, o_insert_dropped && $stable(r_count), "full insert not dropped")

endmodule

/* src/swq_cell.sv */
// One slot of the sorted queue: holds an entry, compares it with the new key,
// and shifts toward the tail on insert or toward the head on pop. Uses swq_pkg.
module swq_cell (
    input  logic               i_clk,
    input  swq_pkg::t_cell_cmd i_cmd,
    input  logic               i_valid,
    input  swq_pkg::t_entry    i_prev_entry,
    input  logic               i_prev_ge,
    input  swq_pkg::t_entry    i_next_entry,
    output swq_pkg::t_entry    o_entry,
    output logic               o_ge
);
    import swq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   w_ge;

    assign w_ge    = !i_valid || (r_entry.key >= i_cmd.fresh.key);
    assign o_ge    = w_ge;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        priority if (i_cmd.push && w_ge) begin
            n_entry = i_prev_ge ? i_prev_entry : i_cmd.fresh;
        end else if (i_cmd.pop) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

/* dv/swq_checker.sv */
`timescale 1ns / 100ps
// Checker for sorted_wakeup_queue_unit: watches both channels, keeps its own sorted
// wake-up store to predict each result item and compares every field.
// Depends on swq_pkg only.
module swq_checker
    import swq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_op,
    input  logic [ID_W-1:0]      i_proc_id,
    input  logic [KEY_W-1:0]     i_wake_time,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_pop_valid,
    input  logic [ID_W-1:0]      i_popped_id,
    input  logic [KEY_W-1:0]     i_popped_wake,
    input  logic [KEY_W-1:0]     i_head_wake,
    input  logic                 i_queue_empty,
    input  logic [CNT_OUT_W-1:0] i_entry_count,
    input  logic                 i_insert_dropped,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic                 pop_valid;
        logic [ID_W-1:0]      popped_id;
        logic [KEY_W-1:0]     popped_wake;
        logic [KEY_W-1:0]     head_wake;
        logic                 queue_empty;
        logic [CNT_OUT_W-1:0] entry_count;
        logic                 insert_dropped;
    } t_wake_result;

    logic [KEY_W-1:0] sleep_key [CAPACITY];
    logic [ID_W-1:0]  sleep_id  [CAPACITY];
    int               sleep_count = 0;
    t_wake_result     due_results [$];
    t_wake_result     want_result;
    t_wake_result     next_result;
    int               fail_count = 0;
    int               r_pending = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = r_pending;

    task automatic predict_wakeup(input t_op op, input logic [ID_W-1:0] pid,
                                  input logic [KEY_W-1:0] wt, output t_wake_result res);
        int slot;
        res = '0;
        if (op == OP_INSERT) begin
            if (sleep_count >= CAPACITY) begin
                res.insert_dropped = 1'b1;
            end else begin
                slot = 0;
                while (slot < sleep_count && wt > sleep_key[slot])
                    slot++;
                for (int k = sleep_count; k > slot; k--) begin
                    sleep_key[k] = sleep_key[k-1];
                    sleep_id[k]  = sleep_id[k-1];
                end
                sleep_key[slot] = wt;
                sleep_id[slot]  = pid;
                sleep_count++;
            end
        end else if (sleep_count > 0) begin
            res.pop_valid   = 1'b1;
            res.popped_id   = sleep_id[0];
            res.popped_wake = sleep_key[0];
            for (int k = 1; k < sleep_count; k++) begin
                sleep_key[k-1] = sleep_key[k];
                sleep_id[k-1]  = sleep_id[k];
            end
            sleep_count--;
        end
        res.queue_empty = (sleep_count == 0);
        res.head_wake   = (sleep_count > 0) ? sleep_key[0] : '0;
        res.entry_count = CNT_OUT_W'(sleep_count);
    endtask

    task automatic check_field(input string field, input logic [KEY_W-1:0] want,
                               input logic [KEY_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sleep_count = 0;
            due_results.delete();
            r_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    $error("result item with no request waiting");
                    fail_count++;
                end else begin
                    want_result = due_results.pop_front();
                    check_field("pop_valid", KEY_W'(want_result.pop_valid),
                                KEY_W'(i_pop_valid));
                    check_field("popped_id", KEY_W'(want_result.popped_id),
                                KEY_W'(i_popped_id));
                    check_field("popped_wake", want_result.popped_wake, i_popped_wake);
                    check_field("head_wake", want_result.head_wake, i_head_wake);
                    check_field("queue_empty", KEY_W'(want_result.queue_empty),
                                KEY_W'(i_queue_empty));
                    check_field("entry_count", KEY_W'(want_result.entry_count),
                                KEY_W'(i_entry_count));
                    check_field("insert_dropped", KEY_W'(want_result.insert_dropped),
                                KEY_W'(i_insert_dropped));
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_wakeup(t_op'(i_op), i_proc_id, i_wake_time, next_result);
                due_results.push_back(next_result);
            end
            r_pending <= due_results.size();
        end
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Top of the sorted wake-up queue testbench: clock, reset, item stimulus and verdict.
// Depends on swq_pkg, sorted_wakeup_queue_unit and swq_checker.
module tb_top;
    import swq_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 1830;
    localparam int HOLD_CYCLES  = 64;

    logic                 r_clk = 1'b0;
    logic                 r_rst_n = 1'b0;
    logic                 r_valid = 1'b0;
    t_op                  r_op = OP_INSERT;
    logic [ID_W-1:0]      r_proc_id = '0;
    logic [KEY_W-1:0]     r_wake_time = '0;
    logic                 r_ready = 1'b0;
    logic                 r_calm = 1'b0;
    int                   r_hold_seq = 0;
    int                   hold_seen = 0;
    int                   hold_left = 0;
    bit                   sender_calm = 1'b0;

    logic                 o_ready;
    logic                 o_valid;
    logic                 o_pop_valid;
    logic [ID_W-1:0]      o_popped_id;
    logic [KEY_W-1:0]     o_popped_wake;
    logic [KEY_W-1:0]     o_head_wake;
    logic                 o_queue_empty;
    logic [CNT_OUT_W-1:0] o_entry_count;
    logic                 o_insert_dropped;
    int                   fail_count;
    int                   pending;

    always begin
        #5 r_clk = 1'b1;
        #5 r_clk = 1'b0;
    end

    sorted_wakeup_queue_unit #(.CAPACITY(CAPACITY)) i_dut (
        .i_clk            (r_clk),
        .i_rst_n          (r_rst_n),
        .i_valid          (r_valid),
        .o_ready          (o_ready),
        .i_op             (r_op),
        .i_proc_id        (r_proc_id),
        .i_wake_time      (r_wake_time),
        .o_valid          (o_valid),
        .i_ready          (r_ready),
        .o_pop_valid      (o_pop_valid),
        .o_popped_id      (o_popped_id),
        .o_popped_wake    (o_popped_wake),
        .o_head_wake      (o_head_wake),
        .o_queue_empty    (o_queue_empty),
        .o_entry_count    (o_entry_count),
        .o_insert_dropped (o_insert_dropped)
    );

    swq_checker #(.CAPACITY(CAPACITY)) i_checker (
        .i_clk            (r_clk),
        .i_rst_n          (r_rst_n),
        .i_in_valid       (r_valid),
        .i_in_ready       (o_ready),
        .i_op             (r_op),
        .i_proc_id        (r_proc_id),
        .i_wake_time      (r_wake_time),
        .i_out_valid      (o_valid),
        .i_out_ready      (r_ready),
        .i_pop_valid      (o_pop_valid),
        .i_popped_id      (o_popped_id),
        .i_popped_wake    (o_popped_wake),
        .i_head_wake      (o_head_wake),
        .i_queue_empty    (o_queue_empty),
        .i_entry_count    (o_entry_count),
        .i_insert_dropped (o_insert_dropped),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // hold off for a long stretch whenever a new hold request shows up
    always @(posedge r_clk) begin
        if (r_hold_seq != hold_seen) begin
            hold_seen <= r_hold_seq;
            hold_left <= HOLD_CYCLES;
            r_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            r_ready   <= 1'b0;
        end else if (r_calm) begin
            r_ready <= 1'b1;
        end else begin
            r_ready <= ($urandom_range(0, 99) >= 22);
        end
    end

    function automatic logic [KEY_W-1:0] pick_wake();
        case ($urandom_range(0, 3))
            0: return KEY_W'($urandom_range(0, 15));
            1: return $urandom();
            2: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
            default: return 32'hFFFF_FFF0 | KEY_W'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic send_item(input t_op op, input logic [ID_W-1:0] pid,
                             input logic [KEY_W-1:0] wt);
        int gap;
        gap = 0;
        if (!sender_calm && $urandom_range(0, 99) < 10)
            gap = $urandom_range(1, 4);
        if (gap != 0) begin
            r_valid <= 1'b0;
            repeat (gap) @(posedge r_clk);
        end
        r_valid     <= 1'b1;
        r_op        <= op;
        r_proc_id   <= pid;
        r_wake_time <= wt;
        @(posedge r_clk);
        while (!o_ready)
            @(posedge r_clk);
    endtask

    task automatic send_random(input int insert_pct);
        t_op op;
        op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_POP;
        send_item(op, ID_W'($urandom_range(0, 255)), pick_wake());
    endtask

    initial begin
        int sent;
        int chunk;
        int chunk_len;
        int insert_pct;
        int drain_wait;

        repeat (5) @(posedge r_clk);
        r_rst_n <= 1'b1;

        // empty pop, extremes, equal keys, fill up and overflow
        send_item(OP_POP, 8'hA5, 32'h1234_5678);
        send_item(OP_INSERT, 8'hFF, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 8'h00, 32'h0000_0000);
        send_item(OP_INSERT, 8'h11, 32'd100);
        send_item(OP_INSERT, 8'h22, 32'd100);
        send_item(OP_INSERT, 8'h33, 32'hFFFF_FFFF);
        send_item(OP_POP, 8'h00, 32'h0);
        send_item(OP_POP, 8'hFF, 32'hFFFF_FFFF);
        for (int k = 0; k < CAPACITY - 3; k++)
            send_item(OP_INSERT, ID_W'(8'h40 + k), KEY_W'(k * 37));
        send_item(OP_INSERT, 8'h5A, 32'd50);
        send_item(OP_POP, 8'h5A, 32'd50);

        // pause until every result has come back
        r_valid <= 1'b0;
        @(posedge r_clk);
        while (pending != 0)
            @(posedge r_clk);

        // long receiver hold-off while the sender keeps offering
        sender_calm = 1'b1;
        r_hold_seq <= r_hold_seq + 1;
        for (int k = 0; k < 20; k++)
            send_random(80);
        sender_calm = 1'b0;

        sent  = 0;
        chunk = 0;
        while (sent < RANDOM_ITEMS) begin
            chunk_len = $urandom_range(20, 60);
            case (chunk % 3)
                0: insert_pct = 80;
                1: insert_pct = 25;
                default: insert_pct = 50;
            endcase
            sender_calm = (chunk >= 8 && chunk < 12);
            r_calm <= sender_calm;
            for (int k = 0; k < chunk_len && sent < RANDOM_ITEMS; k++) begin
                send_random(insert_pct);
                sent++;
            end
            chunk++;
        end
        r_valid <= 1'b0;

        drain_wait = 0;
        while (pending != 0 && drain_wait < 2000) begin
            @(posedge r_clk);
            drain_wait++;
        end
        repeat (4) @(posedge r_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #2ms;
        $display("FAIL");
        $finish;
    end

endmodule
